// ----- sv/rgma_pkg.sv -----
// Shared types and constants for the range-gated moving average block.
package rgma_pkg;

  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam int CFG_INDEX_W = 1;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_UPPER_LIMIT = 1'b0;
  localparam cfg_index_t REG_LOWER_LIMIT = 1'b1;

  localparam sample_t UPPER_LIMIT_RESET = 16'sd10000;
  localparam sample_t LOWER_LIMIT_RESET = -16'sd4000;

endpackage

// ----- sv/rgma_ring.sv -----
// Sample ring memory: one write port, one read port with registered data.
module rgma_ring #(
  parameter int DEPTH  = 10,
  parameter int ADDR_W = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  rgma_pkg::sample_t     wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output rgma_pkg::sample_t     rdata
);

  rgma_pkg::sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/rgma_div.sv -----
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module rgma_div #(
  parameter int SUM_W = 20,
  parameter int DEN_W = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    done,
  output rgma_pkg::sample_t       quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  rem_next;
  logic [SUM_W-1:0]  quo;
  logic [SUM_W-1:0]  quo_next;
  logic [SUM_W-1:0]  quo_signed;
  logic [DEN_W-1:0]  den;
  logic              neg;
  logic [DEN_W:0]    shifted;
  logic [SUM_W-1:0]  magnitude;

  assign magnitude = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  always_comb begin
    shifted = {rem, quo[SUM_W-1]};
    if (shifted >= {1'b0, den}) begin
      rem_next = DEN_W'(shifted - {1'b0, den});
      quo_next = {quo[SUM_W-2:0], 1'b1};
    end else begin
      rem_next = shifted[DEN_W-1:0];
      quo_next = {quo[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= magnitude;
      den <= divisor;
      neg <= dividend[SUM_W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = quo_signed[rgma_pkg::SAMPLE_W-1:0];

endmodule

// ----- sv/range_gated_moving_average_unit.sv -----
// Range-gated moving average: top level with limit registers, sequencer and output word.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample) takes one signed reading
//   in hundredths. result channel (result_valid/result_ready/filtered/rejected)
//   returns exactly one word per sample. cfg channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) writes upper_limit (index 0) or lower_limit (index 1);
//   it is always ready; the user must write it only while no sample is in
//   flight, since the block itself does not enforce this.
// Flow: an in-range sample is read from the ring, updates the sum, goes
//   through the serial divider and is then loaded into the output word. An
//   out-of-range sample skips the ring read and the update and goes straight
//   to the divider, or straight to the output word when the ring is still
//   empty. The serial divider sets the rate; one sample is processed at a
//   time, and the next is taken only once the sequencer is back in idle.
// Reset clears the limits to 100.00 / -40.00, the fill count, slot and sum;
//   the ring contents are not cleared and are only used once written.
// Stall: the output word holds while result_ready is low; a new sample is
//   still taken, and its result waits until the output word is free.
module range_gated_moving_average_unit #(
  parameter int WINDOW = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  input  rgma_pkg::sample_t            sample,
  output logic                         result_valid,
  input  logic                         result_ready,
  output rgma_pkg::sample_t            filtered,
  output logic                         rejected,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  rgma_pkg::cfg_index_t         cfg_index,
  input  rgma_pkg::sample_t            cfg_data
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = rgma_pkg::SAMPLE_W + $clog2(WINDOW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]              state;
  rgma_pkg::sample_t       upper_limit;
  rgma_pkg::sample_t       lower_limit;
  logic [SLOT_W-1:0]       slot;
  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        fill_next;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  rgma_pkg::sample_t       sample_hold;
  logic                    rej_hold;
  rgma_pkg::sample_t       pend_val;

  logic                    accept;
  logic                    out_of_range;
  logic                    full;
  logic                    ring_we;
  logic                    ring_re;
  rgma_pkg::sample_t       ring_rdata;
  logic                    div_start;
  logic signed [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0]        div_divisor;
  logic                    div_done;
  rgma_pkg::sample_t       div_quotient;
  logic                    out_free;

  assign cfg_ready    = 1'b1;
  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign out_of_range = (sample > upper_limit) || (sample < lower_limit);
  assign full         = (fill == CNT_W'(WINDOW));
  assign out_free     = !result_valid || result_ready;

  assign ring_re = accept && !out_of_range;
  assign ring_we = (state == ST_UPD);

  assign fill_next = full ? fill : fill + 1'b1;
  assign sum_next  = sum - (full ? SUM_W'(ring_rdata) : '0) + SUM_W'(sample_hold);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum;
    div_divisor  = fill;
    if (accept && out_of_range && (fill != '0)) begin
      div_start = 1'b1;
    end else if (state == ST_UPD) begin
      div_start    = 1'b1;
      div_dividend = sum_next;
      div_divisor  = fill_next;
    end
  end

  rgma_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot),
    .wdata (sample_hold),
    .re    (ring_re),
    .raddr (slot),
    .rdata (ring_rdata)
  );

  rgma_div #(
    .SUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= rgma_pkg::UPPER_LIMIT_RESET;
      lower_limit <= rgma_pkg::LOWER_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rgma_pkg::REG_UPPER_LIMIT: upper_limit <= cfg_data;
        rgma_pkg::REG_LOWER_LIMIT: lower_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot         <= '0;
      fill         <= '0;
      sum          <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == ST_HOLD) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!out_of_range) begin
              state <= ST_UPD;
            end else if (fill == '0) begin
              state <= ST_HOLD;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_UPD: begin
          sum   <= sum_next;
          fill  <= fill_next;
          slot  <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_hold <= sample;
      rej_hold    <= out_of_range;
      pend_val    <= sample;
    end else if ((state == ST_DIV) && div_done) begin
      pend_val <= div_quotient;
    end
    if ((state == ST_HOLD) && out_free) begin
      filtered <= pend_val;
      rejected <= rej_hold;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW))
    else $error("fill count above window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot < SLOT_W'(WINDOW) || WINDOW == 1)
    else $error("write slot outside ring");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (sum == '0))
    else $error("nonzero sum with empty ring");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_hold_to_word: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && out_free) |=> (result_valid && state == ST_IDLE))
    else $error("result not loaded into output word");

endmodule
